// File: rtl/sgd_l1_cumulative_penalty_update_assert.svh
// Assertion macros shared by the penalty update block.
`ifndef SGD_L1_CUMULATIVE_PENALTY_UPDATE_ASSERT_SVH
`define SGD_L1_CUMULATIVE_PENALTY_UPDATE_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define L1CP_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("l1cp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define L1CP_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("l1cp: next-cycle check failed");

`else

`define L1CP_ASSERT_SAME(label, ck, rs, ante, cons)
`define L1CP_ASSERT_NEXT(label, ck, rs, ante, cons)

`endif

`endif

// File: rtl/l1cp_pkg.sv
package l1cp_pkg;

  // Fixed field widths
  localparam int FIDX_W      = 12;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 16;
  localparam int TOTAL_W     = 48;
  localparam int U_W         = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int ALU_W       = 64;

  // Operation codes
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_EPOCH  = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_L1_STRENGTH   = 1'd1;

  localparam logic [CFG_W-1:0] LR_RESET = 16'd655;
  localparam logic [CFG_W-1:0] L1_RESET = 16'd66;

  // Half an LSB of Q16.16 in the finer fraction
  localparam int HALF_LSB = 32768;

  typedef enum logic [3:0] {
    S_IDLE, S_RND, S_Z, S_S, S_T, S_D, S_Q, S_ACC, S_U, S_LD, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ALU_PASS, ALU_SHR16, ALU_SAT_W, ALU_SAT_32, ALU_SAT_TOTAL, ALU_ROUND_U
  } alu_mode_t;

  typedef enum logic [2:0] {
    A_PROD, A_W, A_U, A_Z, A_RES, A_Q, A_TOTAL, A_G
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ZERO, B_HALF, B_TMP, B_Q, B_PROD, B_Z
  } b_sel_t;

  typedef enum logic [2:0] {
    D_NONE, D_TMP, D_Z, D_RES, D_RES_CLAMP, D_TOTAL, D_U
  } dst_t;

  typedef struct packed {
    logic      in_ready;
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    logic      sub;
    alu_mode_t mode;
    dst_t      dst;
    logic      finish;
  } ctrl_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [ALU_W-1:0] v);
    logic signed [ALU_W-1:0] hi;
    logic signed [ALU_W-1:0] lo;
    hi = (ALU_W'(64'sd1) <<< (DATA_W - 1)) - ALU_W'(64'sd1);
    lo = -hi - ALU_W'(64'sd1);
    if (v > hi) begin
      sat_s32 = hi[DATA_W-1:0];
    end else if (v < lo) begin
      sat_s32 = lo[DATA_W-1:0];
    end else begin
      sat_s32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

// File: rtl/l1cp_alu.sv
module l1cp_alu #(
  parameter int WEIGHT_WIDTH = 32
) (
  input  logic signed [l1cp_pkg::ALU_W-1:0] a,
  input  logic signed [l1cp_pkg::ALU_W-1:0] b,
  input  logic                              sub,
  input  l1cp_pkg::alu_mode_t               mode,
  output logic signed [l1cp_pkg::ALU_W-1:0] y
);
  import l1cp_pkg::*;

  localparam logic signed [ALU_W-1:0] W_MAX =
    (ALU_W'(64'sd1) <<< (WEIGHT_WIDTH - 1)) - ALU_W'(64'sd1);
  localparam logic signed [ALU_W-1:0] W_MIN = -W_MAX - ALU_W'(64'sd1);
  localparam logic signed [ALU_W-1:0] T_MAX =
    (ALU_W'(64'sd1) <<< TOTAL_W) - ALU_W'(64'sd1);
  localparam logic signed [ALU_W-1:0] U_MAX =
    (ALU_W'(64'sd1) <<< U_W) - ALU_W'(64'sd1);

  logic signed [ALU_W-1:0] sum;
  logic signed [ALU_W-1:0] shr;

  // Shared add or subtract
  assign sum = sub ? (a - b) : (a + b);
  assign shr = sum >>> 16;

  // Post-process the sum by mode
  always_comb begin
    unique case (mode)
      ALU_PASS:      y = sum;
      ALU_SHR16:     y = shr;
      ALU_SAT_W:     y = (sum > W_MAX) ? W_MAX : ((sum < W_MIN) ? W_MIN : sum);
      ALU_SAT_32:    y = ALU_W'(sat_s32(sum));
      ALU_SAT_TOTAL: y = (sum > T_MAX) ? T_MAX : sum;
      ALU_ROUND_U:   y = (shr > U_MAX) ? U_MAX : shr;
      default:       y = sum;
    endcase
  end

endmodule

// File: rtl/l1cp_store.sv
module l1cp_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int WW    = 32
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  input  logic                                w_we,
  input  logic                                q_we,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [WW-1:0]                w_wdata,
  input  logic signed [l1cp_pkg::DATA_W-1:0]  q_wdata,
  output logic signed [WW-1:0]                w_rdata,
  output logic signed [l1cp_pkg::DATA_W-1:0]  q_rdata
);
  import l1cp_pkg::*;

  logic signed [WW-1:0]     weight_mem  [DEPTH];
  logic signed [DATA_W-1:0] penalty_mem [DEPTH];

  // Write weight and applied penalty
  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[wr_addr] <= w_wdata;
    end
    if (q_we) begin
      penalty_mem[wr_addr] <= q_wdata;
    end
  end

  // Registered read of both stores
  always_ff @(posedge clk) begin
    if (rd_en) begin
      w_rdata <= weight_mem[rd_addr];
      q_rdata <= penalty_mem[rd_addr];
    end
  end

endmodule

// File: rtl/l1cp_seq.sv
`include "sgd_l1_cumulative_penalty_update_assert.svh"

module l1cp_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      operation,
  input  logic            idx_ok,
  input  logic            z_pos,
  input  logic            z_zero,
  input  logic            out_free,
  output l1cp_pkg::ctrl_t ctrl
);
  import l1cp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (operation)
            OP_UPDATE: state_next = idx_ok ? S_RND : S_DONE;
            OP_EPOCH:  state_next = S_ACC;
            OP_LOAD:   state_next = idx_ok ? S_LD : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RND:  state_next = S_Z;
      S_Z:    state_next = S_S;
      S_S:    state_next = z_zero ? S_DONE : S_T;
      S_T:    state_next = S_D;
      S_D:    state_next = S_Q;
      S_Q:    state_next = S_DONE;
      S_ACC:  state_next = S_U;
      S_U:    state_next = S_DONE;
      S_LD:   state_next = S_DONE;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Unit operands and destination per step
  always_comb begin
    ctrl          = '0;
    ctrl.a_sel    = A_PROD;
    ctrl.b_sel    = B_ZERO;
    ctrl.mode     = ALU_PASS;
    ctrl.dst      = D_NONE;
    unique case (state)
      S_IDLE: ctrl.in_ready = 1'b1;
      S_RND: begin
        ctrl.a_sel = A_PROD;
        ctrl.b_sel = B_HALF;
        ctrl.mode  = ALU_SHR16;
        ctrl.dst   = D_TMP;
      end
      S_Z: begin
        ctrl.a_sel = A_W;
        ctrl.b_sel = B_TMP;
        ctrl.mode  = ALU_SAT_W;
        ctrl.dst   = D_Z;
      end
      S_S: begin
        ctrl.a_sel = A_U;
        ctrl.b_sel = B_Q;
        ctrl.sub   = !z_pos;
        ctrl.dst   = D_TMP;
      end
      S_T: begin
        ctrl.a_sel = A_Z;
        ctrl.b_sel = B_TMP;
        ctrl.sub   = z_pos;
        ctrl.dst   = D_RES_CLAMP;
      end
      S_D: begin
        ctrl.a_sel = A_RES;
        ctrl.b_sel = B_Z;
        ctrl.sub   = 1'b1;
        ctrl.dst   = D_TMP;
      end
      S_Q: begin
        ctrl.a_sel = A_Q;
        ctrl.b_sel = B_TMP;
        ctrl.mode  = ALU_SAT_32;
        ctrl.dst   = D_TMP;
      end
      S_ACC: begin
        ctrl.a_sel = A_TOTAL;
        ctrl.b_sel = B_PROD;
        ctrl.mode  = ALU_SAT_TOTAL;
        ctrl.dst   = D_TOTAL;
      end
      S_U: begin
        ctrl.a_sel = A_TOTAL;
        ctrl.b_sel = B_HALF;
        ctrl.mode  = ALU_ROUND_U;
        ctrl.dst   = D_U;
      end
      S_LD: begin
        ctrl.a_sel = A_G;
        ctrl.b_sel = B_ZERO;
        ctrl.mode  = ALU_SAT_W;
        ctrl.dst   = D_RES;
      end
      S_DONE: ctrl.finish = out_free;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

  `L1CP_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && ctrl.in_ready, !ctrl.in_ready)
  `L1CP_ASSERT_NEXT(a_idle_after_finish, clk, rst, ctrl.finish, ctrl.in_ready)

endmodule

// File: rtl/sgd_l1_cumulative_penalty_update.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | operation, feature_index, gradient
// out     | output    | out_valid / out_ready| result_index, new_weight, total_penalty,
//         |           |                      | clipped_to_zero
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One shared adder with saturation does every step under a small sequencer.
// A word is taken only once the last is finished, which may wait on out_ready;
// an update ends early on a zero sum, idle words and out-of-range indexes at once.
// Synchronous reset clears the total and the sequencer, presets the rates; the
// weight and penalty stores are not cleared and must be loaded before use.
// A finished word waits in the output register; the next word is taken while it does.

`include "sgd_l1_cumulative_penalty_update_assert.svh"

module sgd_l1_cumulative_penalty_update #(
  parameter int FEATURE_COUNT = 4096,
  parameter int WEIGHT_WIDTH  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              operation,
  input  logic [l1cp_pkg::FIDX_W-1:0]             feature_index,
  input  logic signed [l1cp_pkg::DATA_W-1:0]      gradient,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [l1cp_pkg::FIDX_W-1:0]             result_index,
  output logic signed [l1cp_pkg::DATA_W-1:0]      new_weight,
  output logic [l1cp_pkg::U_W-1:0]                total_penalty,
  output logic                                    clipped_to_zero,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [l1cp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [l1cp_pkg::CFG_W-1:0]              cfg_data
);
  import l1cp_pkg::*;

  localparam int AW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int IXW = (AW > FIDX_W) ? AW : FIDX_W;

  ctrl_t ctrl;

  logic [CFG_W-1:0]          learning_rate;
  logic [CFG_W-1:0]          l1_strength;
  logic [TOTAL_W-1:0]        total;
  logic [U_W-1:0]            u;

  logic [1:0]                op_r;
  logic [FIDX_W-1:0]         idx_r;
  logic [AW-1:0]             addr_r;
  logic                      idx_ok_r;
  logic signed [DATA_W-1:0]  g_r;
  logic signed [ALU_W-1:0]   prod;
  logic signed [ALU_W-1:0]   tmp;
  logic signed [WEIGHT_WIDTH-1:0] z;
  logic signed [WEIGHT_WIDTH-1:0] res;

  logic [IXW-1:0]            idx_wide;
  logic [AW-1:0]             rd_addr;
  logic                      idx_ok;
  logic                      accept;
  logic signed [16:0]        mul_a;
  logic signed [32:0]        mul_b;
  logic signed [49:0]        mul_p;
  logic signed [ALU_W-1:0]   alu_a;
  logic signed [ALU_W-1:0]   alu_b;
  logic signed [ALU_W-1:0]   alu_y;
  logic signed [ALU_W-1:0]   clamp_y;
  logic signed [WEIGHT_WIDTH-1:0] w_rdata;
  logic signed [DATA_W-1:0]  q_rdata;
  logic                      z_zero;
  logic                      z_pos;
  logic                      out_free;
  logic                      is_upd;
  logic                      w_we;
  logic                      q_we;
  logic signed [DATA_W-1:0]  q_wdata;

  assign accept    = in_valid && in_ready;
  assign in_ready  = ctrl.in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Decode index against the store depth
  assign idx_wide = IXW'(feature_index);
  assign rd_addr  = idx_wide[AW-1:0];
  assign idx_ok   = (32'(feature_index) < 32'(FEATURE_COUNT));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      l1_strength   <= L1_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: learning_rate <= cfg_data;
        REG_L1_STRENGTH:   l1_strength   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiply rate by gradient, or by L1 strength on an epoch word
  assign mul_a = $signed({1'b0, learning_rate});
  assign mul_b = (operation == OP_EPOCH) ? $signed({17'b0, l1_strength})
                                         : $signed({gradient[DATA_W-1], gradient});
  assign mul_p = mul_a * mul_b;

  // Capture the word on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= operation;
      idx_r    <= feature_index;
      addr_r   <= rd_addr;
      idx_ok_r <= idx_ok;
      g_r      <= gradient;
      prod     <= ALU_W'(mul_p);
    end
  end

  assign z_zero = (z == '0);
  assign z_pos  = !z[WEIGHT_WIDTH-1] && !z_zero;

  // Operand selection for the shared unit
  always_comb begin
    case (ctrl.a_sel)
      A_PROD:  alu_a = prod;
      A_W:     alu_a = ALU_W'(w_rdata);
      A_U:     alu_a = ALU_W'(u);
      A_Z:     alu_a = ALU_W'(z);
      A_RES:   alu_a = ALU_W'(res);
      A_Q:     alu_a = ALU_W'(q_rdata);
      A_TOTAL: alu_a = ALU_W'(total);
      A_G:     alu_a = ALU_W'(g_r);
      default: alu_a = '0;
    endcase
    case (ctrl.b_sel)
      B_ZERO:  alu_b = '0;
      B_HALF:  alu_b = ALU_W'(HALF_LSB);
      B_TMP:   alu_b = tmp;
      B_Q:     alu_b = ALU_W'(q_rdata);
      B_PROD:  alu_b = prod;
      B_Z:     alu_b = ALU_W'(z);
      default: alu_b = '0;
    endcase
  end

  l1cp_alu #(
    .WEIGHT_WIDTH(WEIGHT_WIDTH)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (ctrl.sub),
    .mode (ctrl.mode),
    .y    (alu_y)
  );

  // Clip at zero towards the sign of the summed weight
  always_comb begin
    if (z_pos) begin
      clamp_y = alu_y[ALU_W-1] ? '0 : alu_y;
    end else begin
      clamp_y = (alu_y > 0) ? '0 : alu_y;
    end
  end

  // Write back the unit's result
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= '0;
    end else begin
      case (ctrl.dst)
        D_TMP:       tmp <= alu_y;
        D_Z:         z   <= alu_y[WEIGHT_WIDTH-1:0];
        D_RES:       res <= alu_y[WEIGHT_WIDTH-1:0];
        D_RES_CLAMP: res <= clamp_y[WEIGHT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Running total and its rounded form
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      u     <= '0;
    end else begin
      if (ctrl.dst == D_TOTAL) begin
        total <= alu_y[TOTAL_W-1:0];
      end
      if (ctrl.dst == D_U) begin
        u <= alu_y[U_W-1:0];
      end
    end
  end

  // Store writes on finish
  assign is_upd  = (op_r == OP_UPDATE);
  assign w_we    = ctrl.finish && idx_ok_r && (is_upd || op_r == OP_LOAD);
  assign q_we    = ctrl.finish && idx_ok_r && ((op_r == OP_LOAD) || (is_upd && !z_zero));
  assign q_wdata = (op_r == OP_LOAD) ? '0 : tmp[DATA_W-1:0];

  l1cp_store #(
    .DEPTH (FEATURE_COUNT),
    .AW    (AW),
    .WW    (WEIGHT_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .w_we    (w_we),
    .q_we    (q_we),
    .wr_addr (addr_r),
    .w_wdata (res),
    .q_wdata (q_wdata),
    .w_rdata (w_rdata),
    .q_rdata (q_rdata)
  );

  l1cp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .idx_ok    (idx_ok),
    .z_pos     (z_pos),
    .z_zero    (z_zero),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      result_index    <= idx_r;
      new_weight      <= sat_s32(ALU_W'(res));
      total_penalty   <= u;
      clipped_to_zero <= is_upd && idx_ok_r && !z_zero && (res == '0);
    end
  end

  `L1CP_ASSERT_NEXT(a_total_kept, clk, rst, accept && operation != OP_EPOCH, total == $past(total))
  `L1CP_ASSERT_NEXT(a_total_grows, clk, rst, accept && operation == OP_EPOCH, total >= $past(total))
  `L1CP_ASSERT_SAME(a_clip_is_zero, clk, rst, out_valid && clipped_to_zero, new_weight == '0)

endmodule

// File: tb/l1cp_result_checker.sv
`timescale 1ns / 1ps

module l1cp_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        operation,
  input  logic [l1cp_pkg::FIDX_W-1:0]       feature_index,
  input  logic signed [l1cp_pkg::DATA_W-1:0] gradient,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [l1cp_pkg::FIDX_W-1:0]       result_index,
  input  logic signed [l1cp_pkg::DATA_W-1:0] new_weight,
  input  logic [l1cp_pkg::U_W-1:0]          total_penalty,
  input  logic                              clipped_to_zero,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [l1cp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [l1cp_pkg::CFG_W-1:0]        cfg_data,
  output int                                errors,
  output int                                pending
);
  import l1cp_pkg::*;

  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam longint TOTAL_MAX = 64'sd281474976710655;
  localparam longint U_MAX     = 64'sd4294967295;

  typedef struct packed {
    logic [FIDX_W-1:0]        index;
    logic signed [DATA_W-1:0] weight;
    logic [U_W-1:0]           total;
    logic                     clipped;
  } result_word_t;

  // Shadow copy of the block's state
  logic [CFG_W-1:0]         rate;
  logic [CFG_W-1:0]         strength;
  logic [TOTAL_W-1:0]       total_acc;
  logic signed [DATA_W-1:0] weight_mem [4096];
  logic signed [DATA_W-1:0] penalty_mem [4096];

  result_word_t due_words [$];
  result_word_t seen;
  result_word_t want;
  int           mismatches;

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Round the Q16.32 total to Q16.16, saturating at the 32-bit top
  function automatic logic [U_W-1:0] rounded_total(input logic [TOTAL_W-1:0] t);
    longint x;
    x = (longint'(t) + HALF_LSB) >>> 16;
    if (x > U_MAX) x = U_MAX;
    return x[U_W-1:0];
  endfunction

  // Apply one input word to the shadow state and form its result word
  task automatic apply_word(input logic [1:0] op, input logic [FIDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] g, output result_word_t r);
    longint u;
    longint q;
    longint step;
    longint z;
    longint t;
    longint res;
    longint sum;
    r.index   = idx;
    r.weight  = '0;
    r.clipped = 1'b0;
    case (op)
      OP_EPOCH: begin
        sum = longint'(total_acc) + longint'(rate) * longint'(strength);
        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
        total_acc = sum[TOTAL_W-1:0];
      end
      OP_LOAD: begin
        weight_mem[idx]  = g;
        penalty_mem[idx] = '0;
        r.weight         = g;
      end
      OP_UPDATE: begin
        u    = longint'(rounded_total(total_acc));
        q    = longint'(penalty_mem[idx]);
        step = (longint'(rate) * longint'(g) + HALF_LSB) >>> 16;
        z    = clamp_s32(longint'(weight_mem[idx]) + step);
        res  = 0;
        // Pull towards zero by the penalty not yet applied, never past zero
        if (z > 0) begin
          t   = z - (u + q);
          res = (t > 0) ? t : 0;
        end else if (z < 0) begin
          t   = z + (u - q);
          res = (t < 0) ? t : 0;
        end
        if (z != 0) begin
          penalty_mem[idx] = DATA_W'(clamp_s32(q + (res - z)));
          r.clipped        = (res == 0);
        end
        weight_mem[idx] = res[DATA_W-1:0];
        r.weight        = res[DATA_W-1:0];
      end
      default: ;
    endcase
    r.total = rounded_total(total_acc);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rate       = LR_RESET;
      strength   = L1_RESET;
      total_acc  = '0;
      mismatches = 0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LEARNING_RATE) rate = cfg_data;
        else if (cfg_index == REG_L1_STRENGTH) strength = cfg_data;
      end
      // Compare the outgoing word with the oldest one due
      if (out_valid && out_ready) begin
        seen = '{result_index, new_weight, total_penalty, clipped_to_zero};
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: index %0d weight %0d total %0d clip %0d",
                     seen.index, seen.weight, seen.total, seen.clipped);
        end else begin
          want = due_words.pop_front();
          if (seen != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch %0d: index %0d/%0d weight %0d/%0d total %0d/%0d clip %0d/%0d",
                       mismatches, want.index, seen.index, want.weight, seen.weight,
                       want.total, seen.total, want.clipped, seen.clipped);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_word(operation, feature_index, gradient, want);
        due_words.insert(due_words.size(), want);
      end
    end
    pending <= due_words.size();
    errors  <= mismatches;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import l1cp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 76;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               operation = OP_NONE;
  logic [FIDX_W-1:0]        feature_index = '0;
  logic signed [DATA_W-1:0] gradient = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [FIDX_W-1:0]        result_index;
  logic signed [DATA_W-1:0] new_weight;
  logic [U_W-1:0]           total_penalty;
  logic                     clipped_to_zero;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_LEARNING_RATE;
  logic [CFG_W-1:0]         cfg_data = '0;

  int errors;
  int pending;
  int cycles = 0;
  int hold_left = 0;
  logic steady = 1'b0;

  // Weights that have been loaded and so may be updated
  bit loaded [4096];
  int loaded_list [$];

  int n_update = 0;
  int n_epoch = 0;
  int n_load = 0;
  int n_none = 0;
  int n_settings = 1;

  sgd_l1_cumulative_penalty_update dut (.*);

  l1cp_result_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up well past the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sgd_l1_cumulative_penalty_update regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stall the result side at random, except in steady stretches
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      hold_left <= idle_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [DATA_W-1:0] small_signed(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] grad_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return $urandom();
      3, 4:    return small_signed(1 << 24);
      default: return small_signed(1 << 18);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] load_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      4:       return '0;
      default: return small_signed(1 << 20);
    endcase
  endfunction

  // Present one word and hold it until taken
  task automatic send_word(input logic [1:0] op, input logic [FIDX_W-1:0] idx,
                           input logic [DATA_W-1:0] g);
    int gap;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    feature_index <= idx;
    gradient      <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_UPDATE: n_update++;
      OP_EPOCH:  n_epoch++;
      OP_LOAD: begin
        n_load++;
        if (!loaded[idx]) begin
          loaded[idx] = 1'b1;
          loaded_list.insert(loaded_list.size(), int'(idx));
        end
      end
      default:   n_none++;
    endcase
  endtask

  // Drop valid and wait until every result word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_rates(input logic [CFG_W-1:0] lr_v, input logic [CFG_W-1:0] l1_v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_LEARNING_RATE;
    cfg_data  <= lr_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_L1_STRENGTH;
    cfg_data  <= l1_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [FIDX_W-1:0] pick_loaded();
    return FIDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  // Mostly updates on loaded weights, with loads, epochs and some idle words
  task automatic run_phase(input int words);
    int done;
    int r;
    int pause_at;
    logic [FIDX_W-1:0] idx;
    done     = 0;
    pause_at = $urandom_range(10, words - 10);
    while (done < words) begin
      if (done == pause_at) wait_drained();
      r = $urandom_range(0, 99);
      if (loaded_list.size() == 0 || r < 12) begin
        idx = (r % 2 == 1 && loaded_list.size() > 0) ? pick_loaded()
                                                      : FIDX_W'($urandom_range(0, 4095));
        send_word(OP_LOAD, idx, load_value());
        done++;
      end else if (r < 21) begin
        send_word(OP_EPOCH, FIDX_W'($urandom_range(0, 4095)), $urandom());
        done++;
      end else if (r < 24) begin
        send_word(OP_NONE, FIDX_W'($urandom_range(0, 4095)), $urandom());
      end else begin
        send_word(OP_UPDATE, pick_loaded(), grad_value());
        done++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] lr_set [7];
    logic [CFG_W-1:0] l1_set [7];
    lr_set = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, LR_RESET};
    l1_set = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, L1_RESET};
    lr_set[4] = CFG_W'($urandom());
    l1_set[4] = CFG_W'($urandom());
    lr_set[5] = CFG_W'($urandom());
    l1_set[5] = CFG_W'($urandom());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero sum, clipping, saturation, idle word
    send_word(OP_LOAD, 12'd0, 32'h0000_0000);
    send_word(OP_LOAD, 12'd4095, 32'h7FFF_FFFF);
    send_word(OP_LOAD, 12'd1, 32'h8000_0000);
    send_word(OP_LOAD, 12'd2, 32'h0001_0000);
    send_word(OP_LOAD, 12'd3, 32'hFFFF_0000);
    send_word(OP_LOAD, 12'd5, 32'h0000_0001);
    send_word(OP_LOAD, 12'd6, 32'hFFFF_FFFF);
    send_word(OP_NONE, 12'd4095, 32'hFFFF_FFFF);
    send_word(OP_UPDATE, 12'd0, 32'h0000_0000);
    send_word(OP_UPDATE, 12'd2, 32'h0000_0000);
    send_word(OP_EPOCH, 12'd0, 32'h0000_0000);
    send_word(OP_EPOCH, 12'd4095, 32'hFFFF_FFFF);
    send_word(OP_UPDATE, 12'd5, 32'h0000_0000);
    send_word(OP_UPDATE, 12'd6, 32'h0000_0000);
    send_word(OP_UPDATE, 12'd4095, 32'h7FFF_FFFF);
    send_word(OP_UPDATE, 12'd1, 32'h8000_0000);
    send_word(OP_UPDATE, 12'd2, 32'h0040_0000);
    send_word(OP_UPDATE, 12'd3, 32'hFFC0_0000);
    send_word(OP_UPDATE, 12'd2, 32'hFFFF_FFFF);
    send_word(OP_EPOCH, 12'd7, 32'h1234_5678);
    send_word(OP_UPDATE, 12'd0, 32'h7FFF_FFFF);
    send_word(OP_UPDATE, 12'd0, 32'h8000_0000);
    send_word(OP_NONE, 12'd0, 32'h0000_0000);

    // Random phases, one per rate setting
    for (int p = 0; p < 7; p++) begin
      set_rates(lr_set[p], l1_set[p]);
      steady <= (p % 3 == 2);
      run_phase(PHASE_WORDS);
    end

    // Let the last words drain, then settle
    steady <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d updates, %0d epochs, %0d loads and %0d idle words",
             n_update, n_epoch, n_load, n_none);
    $display("over %0d rate settings with random gaps and result stalls", n_settings);
    if (errors == 0 && pending == 0) begin
      $display("sgd_l1_cumulative_penalty_update regression: pass");
    end else begin
      $display("sgd_l1_cumulative_penalty_update regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/l1cp_pkg.sv
rtl/l1cp_alu.sv
rtl/l1cp_store.sv
rtl/l1cp_seq.sv
rtl/sgd_l1_cumulative_penalty_update.sv
tb/l1cp_result_checker.sv
tb/tb.sv
